// ----- src/assert_macros.svh -----
// assertion macros shared by the split bitset unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define SBU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("split bitset unit assertion failed");

// next-cycle implication
`define SBU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("split bitset unit assertion failed");

`endif

// ----- src/sbu_pkg.sv -----
// types and constants of the split bitset unit
package sbu_pkg;

   localparam int DEF_SET_WIDTH = 64;
   localparam int CNT_W         = 7;
   localparam int CMD_W         = 3;
   localparam int IDX_W         = 6;
   localparam int GRP_BITS      = 8;
   localparam int GRP_CNT_W     = 4;
   localparam int GRP_IDX_W     = 3;

   localparam logic [CNT_W-1:0] COLOR_COUNT_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET    = 3'd0,
      CMD_CLEAR  = 3'd1,
      CMD_TEST   = 3'd2,
      CMD_POS    = 3'd3,
      CMD_COMPL  = 3'd4,
      CMD_COUNT  = 3'd5,
      CMD_COMPAT = 3'd6,
      CMD_WEAK   = 3'd7
   } cmd_type;

   // per-item control travelling down the pipeline
   typedef struct packed {
      cmd_type          cmd;
      logic             option;
      logic [CNT_W-1:0] n;
      logic             a_lsb;
      logic             flag;
      logic             empty;
   } ctl_type;

endpackage

// ----- src/sbu_if.sv -----
// request and response channel interfaces of the split bitset unit
interface sbu_req_if #(
   parameter int SET_WIDTH = sbu_pkg::DEF_SET_WIDTH
) ();
   logic                        valid;
   logic                        ready;
   logic [sbu_pkg::CMD_W-1:0]   cmd;
   logic [SET_WIDTH-1:0]        set_a;
   logic [SET_WIDTH-1:0]        set_b;
   logic [SET_WIDTH-1:0]        set_c;
   logic [sbu_pkg::IDX_W-1:0]   bit_index;
   logic                        option;

   modport source (output valid, cmd, set_a, set_b, set_c, bit_index, option, input ready);
   modport sink (input valid, cmd, set_a, set_b, set_c, bit_index, option, output ready);
endinterface

interface sbu_rsp_if #(
   parameter int SET_WIDTH = sbu_pkg::DEF_SET_WIDTH
) ();
   logic                        valid;
   logic                        ready;
   logic [SET_WIDTH-1:0]        result_set;
   logic [sbu_pkg::CNT_W-1:0]   count;
   logic                        flag;
   logic                        empty_input;

   modport source (output valid, result_set, count, flag, empty_input, input ready);
   modport sink (input valid, result_set, count, flag, empty_input, output ready);
endinterface

// ----- src/sbu_prep.sv -----
// first stage: mask, bit update, split tests and per-byte count and top bit
`include "assert_macros.svh"

module sbu_prep #(
   parameter int SET_WIDTH = sbu_pkg::DEF_SET_WIDTH,
   parameter int NUM_GRP   = (SET_WIDTH + sbu_pkg::GRP_BITS - 1) / sbu_pkg::GRP_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  sbu_pkg::cmd_type                           in_cmd,
   input  logic [SET_WIDTH-1:0]                       in_set_a,
   input  logic [SET_WIDTH-1:0]                       in_set_b,
   input  logic [SET_WIDTH-1:0]                       in_set_c,
   input  logic [sbu_pkg::IDX_W-1:0]                  in_bit_index,
   input  logic                                       in_option,
   input  logic [sbu_pkg::CNT_W-1:0]                  color_count,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output sbu_pkg::ctl_type                           out_ctl,
   output logic [SET_WIDTH-1:0]                       out_set_a,
   output logic [SET_WIDTH-1:0]                       out_mask,
   output logic [SET_WIDTH-1:0]                       out_upd,
   output logic [NUM_GRP*sbu_pkg::GRP_CNT_W-1:0]      out_grp_ones,
   output logic [NUM_GRP*sbu_pkg::GRP_IDX_W-1:0]      out_grp_top,
   output logic [NUM_GRP-1:0]                         out_grp_nz
);
   import sbu_pkg::*;

   localparam int PAD_W = NUM_GRP * GRP_BITS;
   localparam logic [CNT_W-1:0] N_MAX = CNT_W'(SET_WIDTH);

   logic                         valid_ff, valid_in;
   ctl_type                      ctl_ff, ctl_in;
   logic [SET_WIDTH-1:0]         set_a_ff;
   logic [SET_WIDTH-1:0]         mask_ff, mask_in;
   logic [SET_WIDTH-1:0]         upd_ff, upd_in;
   logic [NUM_GRP*GRP_CNT_W-1:0] grp_ones_ff, grp_ones_in;
   logic [NUM_GRP*GRP_IDX_W-1:0] grp_top_ff, grp_top_in;
   logic [NUM_GRP-1:0]           grp_nz_ff, grp_nz_in;

   logic [CNT_W-1:0]     n;
   logic [SET_WIDTH-1:0] bit_sel;
   logic [SET_WIDTH-1:0] am, bm, cm, na, nb, nc;
   logic [PAD_W-1:0]     am_pad, a_pad;
   logic                 pair_ok, weak_p, weak_q;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign n       = (color_count > N_MAX) ? N_MAX : color_count;
   assign bit_sel = SET_WIDTH'(1) << in_bit_index;

   always_comb begin
      for (int i = 0; i < SET_WIDTH; i++) begin
         mask_in[i] = (CNT_W'(i) < n);
      end
   end

   assign am = in_set_a & mask_in;
   assign bm = in_set_b & mask_in;
   assign cm = in_set_c & mask_in;
   assign na = ~in_set_a & mask_in;
   assign nb = ~in_set_b & mask_in;
   assign nc = ~in_set_c & mask_in;

   assign pair_ok = !(|(am & bm)) || !(|(am & nb)) || !(|(na & bm)) || !(|(na & nb));
   assign weak_p  = !(|(am & bm & cm)) || !(|(am & nb & nc)) ||
                    !(|(na & bm & nc)) || !(|(na & nb & cm));
   assign weak_q  = !(|(na & nb & nc)) || !(|(na & bm & cm)) ||
                    !(|(am & nb & cm)) || !(|(am & bm & nc));

   // set keeps bits above the mask, clear drops them
   assign upd_in = (in_cmd == CMD_CLEAR) ? (in_set_a & ~bit_sel & mask_in)
                                         : (in_set_a | (bit_sel & mask_in));

   always_comb begin
      ctl_in        = '0;
      ctl_in.cmd    = in_cmd;
      ctl_in.option = in_option;
      ctl_in.n      = n;
      ctl_in.a_lsb  = in_set_a[0];
      ctl_in.empty  = (in_set_a == '0);
      case (in_cmd)
         CMD_TEST:   ctl_in.flag = |(in_set_a & bit_sel);
         CMD_COMPAT: ctl_in.flag = pair_ok;
         CMD_WEAK:   ctl_in.flag = weak_p && weak_q;
         default:    ctl_in.flag = 1'b0;
      endcase
   end

   assign am_pad = PAD_W'(am);
   assign a_pad  = PAD_W'(in_set_a);

   // byte-wise ones count and highest set bit
   always_comb begin
      logic [GRP_CNT_W-1:0] cnt;
      logic [GRP_IDX_W-1:0] top;
      grp_ones_in = '0;
      grp_top_in  = '0;
      grp_nz_in   = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         cnt = '0;
         top = '0;
         for (int k = 0; k < GRP_BITS; k++) begin
            cnt = cnt + GRP_CNT_W'(am_pad[g*GRP_BITS+k]);
            if (a_pad[g*GRP_BITS+k]) begin
               top = GRP_IDX_W'(k);
            end
         end
         grp_ones_in[g*GRP_CNT_W +: GRP_CNT_W] = cnt;
         grp_top_in[g*GRP_IDX_W +: GRP_IDX_W]  = top;
         grp_nz_in[g] = |a_pad[g*GRP_BITS +: GRP_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ctl_ff      <= ctl_in;
         set_a_ff    <= in_set_a;
         mask_ff     <= mask_in;
         upd_ff      <= upd_in;
         grp_ones_ff <= grp_ones_in;
         grp_top_ff  <= grp_top_in;
         grp_nz_ff   <= grp_nz_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_ctl      = ctl_ff;
   assign out_set_a    = set_a_ff;
   assign out_mask     = mask_ff;
   assign out_upd      = upd_ff;
   assign out_grp_ones = grp_ones_ff;
   assign out_grp_top  = grp_top_ff;
   assign out_grp_nz   = grp_nz_ff;

   `SBU_ASSERT_NXT(a_prep_hold, valid_ff && !out_ready, valid_ff)

endmodule

// ----- src/sbu_reduce.sv -----
// second stage: total ones count and highest set bit index
`include "assert_macros.svh"

module sbu_reduce #(
   parameter int SET_WIDTH = sbu_pkg::DEF_SET_WIDTH,
   parameter int NUM_GRP   = (SET_WIDTH + sbu_pkg::GRP_BITS - 1) / sbu_pkg::GRP_BITS
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  sbu_pkg::ctl_type                           in_ctl,
   input  logic [SET_WIDTH-1:0]                       in_set_a,
   input  logic [SET_WIDTH-1:0]                       in_mask,
   input  logic [SET_WIDTH-1:0]                       in_upd,
   input  logic [NUM_GRP*sbu_pkg::GRP_CNT_W-1:0]      in_grp_ones,
   input  logic [NUM_GRP*sbu_pkg::GRP_IDX_W-1:0]      in_grp_top,
   input  logic [NUM_GRP-1:0]                         in_grp_nz,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output sbu_pkg::ctl_type                           out_ctl,
   output logic [SET_WIDTH-1:0]                       out_set_a,
   output logic [SET_WIDTH-1:0]                       out_mask,
   output logic [SET_WIDTH-1:0]                       out_upd,
   output logic [sbu_pkg::CNT_W-1:0]                  out_ones,
   output logic [sbu_pkg::CNT_W-1:0]                  out_top
);
   import sbu_pkg::*;

   logic                 valid_ff, valid_in;
   ctl_type              ctl_ff;
   logic [SET_WIDTH-1:0] set_a_ff, mask_ff, upd_ff;
   logic [CNT_W-1:0]     ones_ff, ones_in;
   logic [CNT_W-1:0]     top_ff, top_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      ones_in = '0;
      top_in  = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         ones_in = ones_in + CNT_W'(in_grp_ones[g*GRP_CNT_W +: GRP_CNT_W]);
         // highest non-empty byte wins
         if (in_grp_nz[g]) begin
            top_in = CNT_W'(g * GRP_BITS) + CNT_W'(in_grp_top[g*GRP_IDX_W +: GRP_IDX_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ctl_ff   <= in_ctl;
         set_a_ff <= in_set_a;
         mask_ff  <= in_mask;
         upd_ff   <= in_upd;
         ones_ff  <= ones_in;
         top_ff   <= top_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_set_a = set_a_ff;
   assign out_mask  = mask_ff;
   assign out_upd   = upd_ff;
   assign out_ones  = ones_ff;
   assign out_top   = top_ff;

   `SBU_ASSERT_IMP(a_ones_in_range, valid_ff, ones_ff <= ctl_ff.n)

endmodule

// ----- src/sbu_result.sv -----
// third stage: complement decision, count selection and response register
`include "assert_macros.svh"

module sbu_result #(
   parameter int SET_WIDTH = sbu_pkg::DEF_SET_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  sbu_pkg::ctl_type            in_ctl,
   input  logic [SET_WIDTH-1:0]        in_set_a,
   input  logic [SET_WIDTH-1:0]        in_mask,
   input  logic [SET_WIDTH-1:0]        in_upd,
   input  logic [sbu_pkg::CNT_W-1:0]   in_ones,
   input  logic [sbu_pkg::CNT_W-1:0]   in_top,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [SET_WIDTH-1:0]        out_result_set,
   output logic [sbu_pkg::CNT_W-1:0]   out_count,
   output logic                        out_flag,
   output logic                        out_empty_input
);
   import sbu_pkg::*;

   logic                 valid_ff, valid_in;
   logic [SET_WIDTH-1:0] result_set_ff, result_set_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 flag_ff, flag_in;
   logic                 empty_ff, empty_in;

   logic [CNT_W:0]   twice_ones, n_ext;
   logic [CNT_W-1:0] zeros;
   logic             keep;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign twice_ones = {in_ones, 1'b0};
   assign n_ext      = {1'b0, in_ctl.n};
   assign zeros      = in_ctl.n - in_ones;
   // tie on an even split keeps the set when bit 0 is one
   assign keep = in_ctl.option &&
                 ((twice_ones < n_ext) || ((twice_ones == n_ext) && in_ctl.a_lsb));

   always_comb begin
      result_set_in = '0;
      count_in      = '0;
      flag_in       = 1'b0;
      empty_in      = 1'b0;
      unique case (in_ctl.cmd) inside
         CMD_SET, CMD_CLEAR: result_set_in = in_upd;
         CMD_TEST, CMD_COMPAT, CMD_WEAK: flag_in = in_ctl.flag;
         CMD_POS: begin
            empty_in = in_ctl.empty;
            count_in = in_ctl.empty ? '0 : in_top;
         end
         CMD_COMPL: begin
            if (keep) begin
               result_set_in = in_set_a;
            end else begin
               result_set_in = ~in_set_a & in_mask;
               flag_in       = 1'b1;
            end
         end
         CMD_COUNT: begin
            count_in = (in_ctl.option && (zeros > in_ones)) ? zeros : in_ones;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_set_ff <= result_set_in;
         count_ff      <= count_in;
         flag_ff       <= flag_in;
         empty_ff      <= empty_in;
      end
   end

   assign out_valid       = valid_ff;
   assign out_result_set  = result_set_ff;
   assign out_count       = count_ff;
   assign out_flag        = flag_ff;
   assign out_empty_input = empty_ff;

   `SBU_ASSERT_IMP(a_count_in_range, valid_ff, count_ff <= CNT_W'(SET_WIDTH))
   `SBU_ASSERT_IMP(a_empty_quiet, valid_ff && empty_ff,
      count_ff == '0 && result_set_ff == '0 && !flag_ff)

endmodule

// ----- src/split_bitset_unit.sv -----
// top level of the split bitset unit
// Each request carries a command and up to three colour bitsets and yields exactly one
// response: set, clear and test a bit, highest set bit, complement, ones count, and the
// pairwise and three-way split compatibility tests; all but the bit test and highest set
// bit use a mask of the low color_count bits written through the csr port. The unit is a
// three-stage pipeline (masking, split tests and per-byte counts; byte sum and top-bit
// combine; final selection into the response register); a request passes the prep, reduce
// and result registers in turn, and one request is taken every clock while the response
// side is ready. Backpressure on the response side stalls the stages in turn; a stage with
// a free slot keeps accepting. color_count resets to 64 and is clamped to SET_WIDTH when used.
module split_bitset_unit #(
   parameter int SET_WIDTH = sbu_pkg::DEF_SET_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   sbu_req_if.sink                     req_ch,
   sbu_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [sbu_pkg::CNT_W-1:0]   csr_wr_data
);
   import sbu_pkg::*;

   localparam int NUM_GRP = (SET_WIDTH + GRP_BITS - 1) / GRP_BITS;

   logic [CNT_W-1:0] color_count_ff, color_count_in;

   logic                         s1_valid, s1_ready;
   ctl_type                      s1_ctl;
   logic [SET_WIDTH-1:0]         s1_set_a, s1_mask, s1_upd;
   logic [NUM_GRP*GRP_CNT_W-1:0] s1_grp_ones;
   logic [NUM_GRP*GRP_IDX_W-1:0] s1_grp_top;
   logic [NUM_GRP-1:0]           s1_grp_nz;

   logic                 s2_valid, s2_ready;
   ctl_type              s2_ctl;
   logic [SET_WIDTH-1:0] s2_set_a, s2_mask, s2_upd;
   logic [CNT_W-1:0]     s2_ones, s2_top;

   assign color_count_in = csr_wr_en ? csr_wr_data : color_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= COLOR_COUNT_RESET;
      end else begin
         color_count_ff <= color_count_in;
      end
   end

   sbu_prep #(
      .SET_WIDTH (SET_WIDTH),
      .NUM_GRP   (NUM_GRP)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .in_cmd       (cmd_type'(req_ch.cmd)),
      .in_set_a     (req_ch.set_a),
      .in_set_b     (req_ch.set_b),
      .in_set_c     (req_ch.set_c),
      .in_bit_index (req_ch.bit_index),
      .in_option    (req_ch.option),
      .color_count  (color_count_ff),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_ctl      (s1_ctl),
      .out_set_a    (s1_set_a),
      .out_mask     (s1_mask),
      .out_upd      (s1_upd),
      .out_grp_ones (s1_grp_ones),
      .out_grp_top  (s1_grp_top),
      .out_grp_nz   (s1_grp_nz)
   );

   sbu_reduce #(
      .SET_WIDTH (SET_WIDTH),
      .NUM_GRP   (NUM_GRP)
   ) u_reduce (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid),
      .in_ready    (s1_ready),
      .in_ctl      (s1_ctl),
      .in_set_a    (s1_set_a),
      .in_mask     (s1_mask),
      .in_upd      (s1_upd),
      .in_grp_ones (s1_grp_ones),
      .in_grp_top  (s1_grp_top),
      .in_grp_nz   (s1_grp_nz),
      .out_valid   (s2_valid),
      .out_ready   (s2_ready),
      .out_ctl     (s2_ctl),
      .out_set_a   (s2_set_a),
      .out_mask    (s2_mask),
      .out_upd     (s2_upd),
      .out_ones    (s2_ones),
      .out_top     (s2_top)
   );

   sbu_result #(
      .SET_WIDTH (SET_WIDTH)
   ) u_result (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s2_valid),
      .in_ready        (s2_ready),
      .in_ctl          (s2_ctl),
      .in_set_a        (s2_set_a),
      .in_mask         (s2_mask),
      .in_upd          (s2_upd),
      .in_ones         (s2_ones),
      .in_top          (s2_top),
      .out_valid       (rsp_ch.valid),
      .out_ready       (rsp_ch.ready),
      .out_result_set  (rsp_ch.result_set),
      .out_count       (rsp_ch.count),
      .out_flag        (rsp_ch.flag),
      .out_empty_input (rsp_ch.empty_input)
   );

endmodule
